// ===== hdl/cap_pkg.sv =====
// Package for the Clifford attractor plotter: shared types, register indexes
// and polynomial sine constants. No dependencies.
package cap_pkg;
	localparam int unsigned CFG_IDX_W = 3;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COEF_A = 3'd0, REG_COEF_B = 3'd1, REG_COEF_C = 3'd2, REG_COEF_D = 3'd3,
		REG_PLOT_SCALE = 3'd4, REG_START_X = 3'd5, REG_START_Y = 3'd6
	} cfg_reg_t;
	localparam logic signed [31:0] INV_TWO_PI = 32'sd683565276;
	localparam logic [15:0] SIN_A = 16'd25736;
	localparam logic [15:0] SIN_B = 16'd10512;
	localparam logic [15:0] SIN_C = 16'd1160;
	// Request for the shared multiplier: start strobe and two signed operands
	typedef struct packed {
		logic start;
		logic signed [32:0] op_a;
		logic signed [32:0] op_b;
	} mul_req_t;
endpackage

// ===== hdl/cap_mul.sv =====
// Shared signed 33x33 multiplier with a registered product.
// Depends on cap_pkg.
module cap_mul import cap_pkg::*; (
	input  logic                clk,
	input  mul_req_t            req,
	output logic signed [65:0]  prod
);
	always_ff @(posedge clk) begin
		if (req.start) prod <= req.op_a * req.op_b;
	end
endmodule

// ===== hdl/clifford_attractor_plotter_top.sv =====
// Clifford attractor plotter: one attractor iteration per input transaction.
// One shared multiplier is walked through 28 products in sequence (4 sines
// of 6 products each, 2 weights, 2 scalings); in_ready is high only in idle,
// so a new transaction is accepted only after the previous one has finished.
// The output register holds a result while the next transaction computes.
// Reset: asynchronous active low; registers to defaults, point to origin.
module clifford_attractor_plotter_top import cap_pkg::*; #(
	parameter int GRID_W = 256,
	parameter int GRID_H = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 restart,
	input  logic                 plot_enable,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [15:0]   point_x,
	output logic signed [15:0]   point_y,
	output logic [7:0]           pixel_col,
	output logic [7:0]           pixel_row,
	output logic                 pixel_write,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_value
);
	typedef enum logic [2:0] {
		S_IDLE, S_ANG, S_PH, S_POLY, S_WT, S_SCL, S_OUT
	} state_t;

	state_t state_q;
	logic signed [15:0] ca_q, cb_q, cc_q, cd_q, sx_q, sy_q, cx_q, cy_q;
	logic [15:0] scale_q;
	logic plot_q;
	logic [1:0] sin_idx_q;   // which sine: 0 b*y, 1 b*x, 2 a*x, 3 a*y
	logic [2:0] step_q;      // sub step inside a phase
	logic [1:0] quad_q;
	logic [15:0] z_q, z2_q;
	logic signed [13:0] s_q [4];
	logic signed [15:0] nx_q, ny_q;
	logic signed [16:0] sumx_q;
	logic [7:0] col_q, row_q;
	logic wr_q;
	logic signed [65:0] prod;
	mul_req_t req;
	logic [15:0] pq14;
	logic [15:0] t_nx;
	logic out_free;

	cap_mul u_mul (.clk(clk), .req(req), .prod(prod));

	// Product scaled back to Q14, and the next polynomial term built from it
	assign pq14 = 16'(prod[31:0] >> 14);
	assign t_nx = (step_q == 3'd2) ? (SIN_B - pq14) : (SIN_A - pq14);

	// Operand and coefficient selection for the current sine
	logic signed [15:0] coef_sel, val_sel;
	always_comb begin
		case (sin_idx_q)
			2'd0: begin coef_sel = cb_q; val_sel = cy_q; end
			2'd1: begin coef_sel = cb_q; val_sel = cx_q; end
			2'd2: begin coef_sel = ca_q; val_sel = cx_q; end
			default: begin coef_sel = ca_q; val_sel = cy_q; end
		endcase
	end

	// Multiplier request, one product per sub step
	always_comb begin
		req = '0;
		case (state_q)
			S_ANG: begin
				req.start = 1'b1;
				if (step_q == 3'd0) begin
					req.op_a = 33'(coef_sel);
					req.op_b = 33'(val_sel);
				end else begin
					// angle fits in 32 bits signed
					req.op_a = 33'(signed'(prod[31:0]));
					req.op_b = 33'(INV_TWO_PI);
				end
			end
			S_POLY: begin
				// feed each truncated product straight into the next multiply
				req.start = 1'b1;
				case (step_q)
					3'd0: begin req.op_a = 33'(z_q); req.op_b = 33'(z_q); end
					3'd1: begin req.op_a = 33'(SIN_C); req.op_b = 33'(pq14); end
					3'd2: begin req.op_a = 33'(t_nx); req.op_b = 33'(z2_q); end
					default: begin req.op_a = 33'(t_nx); req.op_b = 33'(z_q); end
				endcase
			end
			S_WT: begin
				req.start = 1'b1;
				req.op_a = (step_q == 3'd0) ? 33'(cc_q) : 33'(cd_q);
				req.op_b = (step_q == 3'd0) ? 33'(s_q[1]) : 33'(s_q[3]);
			end
			S_SCL: begin
				req.start = 1'b1;
				req.op_a = (step_q == 3'd0) ? 33'(nx_q) : 33'(ny_q);
				req.op_b = 33'({1'b0, scale_q});
			end
			default: req = '0;
		endcase
	end

	// Phase rounding from the registered angle*inv product
	logic [15:0] ph;
	logic [63:0] ph_sum;
	assign ph_sum = 64'(prod) + 64'h0000_0080_0000_0000;
	assign ph = ph_sum[55:40];

	logic [15:0] sq;
	logic signed [16:0] wt_term;
	logic signed [65:0] wt_r;
	assign wt_r = prod + 66'sd2048;
	assign wt_term = 17'(wt_r >>> 12);
	assign sq = 16'(((prod[31:0] >> 14) + 32'd2) >> 2);

	function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
		if (v > 17'sd32767) return 16'sd32767;
		if (v < -17'sd32768) return -16'sd32768;
		return v[15:0];
	endfunction

	// Pixel mapping: floor shift by 20, offset half grid
	logic signed [45:0] pix;
	assign pix = 46'(prod >>> 20);
	logic signed [45:0] half_w, half_h;
	assign half_w = 46'(GRID_W / 2);
	assign half_h = 46'(GRID_H / 2);
	logic signed [45:0] col_v, row_v;
	assign col_v = pix + half_w;
	assign row_v = pix + half_h;
	logic col_in;
	assign col_in = (col_v >= 0) && (col_v < 46'(GRID_W));
	logic row_in;
	assign row_in = (row_v >= 0) && (row_v < 46'(GRID_H));
	logic col_ok_q;

	// Output register is free when empty or being drained this cycle
	assign out_free = !out_valid || out_ready;
	assign in_ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ca_q <= '0; cb_q <= '0; cc_q <= '0; cd_q <= '0;
			scale_q <= 16'd256; sx_q <= '0; sy_q <= '0;
			cx_q <= '0; cy_q <= '0;
			out_valid <= 1'b0;
			step_q <= '0; sin_idx_q <= '0;
			plot_q <= 1'b0;
			quad_q <= '0; z_q <= '0; z2_q <= '0;
			s_q <= '{default: '0};
			sumx_q <= '0; nx_q <= '0; ny_q <= '0;
			col_q <= '0; row_q <= '0; wr_q <= 1'b0; col_ok_q <= 1'b0;
			point_x <= '0; point_y <= '0;
			pixel_col <= '0; pixel_row <= '0; pixel_write <= 1'b0;
		end else begin
			// Hold config writes whenever presented
			if (cfg_we) begin
				unique case (cfg_index)
					REG_COEF_A: ca_q <= cfg_value;
					REG_COEF_B: cb_q <= cfg_value;
					REG_COEF_C: cc_q <= cfg_value;
					REG_COEF_D: cd_q <= cfg_value;
					REG_PLOT_SCALE: scale_q <= cfg_value;
					REG_START_X: sx_q <= cfg_value;
					REG_START_Y: sy_q <= cfg_value;
					default: ;
				endcase
			end
			if (state_q == S_OUT && out_free) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: if (in_valid && in_ready) begin
					if (restart) begin cx_q <= sx_q; cy_q <= sy_q; end
					plot_q <= plot_enable;
					sin_idx_q <= '0; step_q <= '0;
					state_q <= S_ANG;
				end
				S_ANG: begin
					// step 0 issues coef*val, step 1 issues angle*inv
					if (step_q == 3'd1) begin step_q <= '0; state_q <= S_PH; end
					else step_q <= step_q + 3'd1;
				end
				S_PH: begin
					quad_q <= ph[15:14];
					z_q <= ph[14] ? (16'h4000 - {2'b0, ph[13:0]}) : {2'b0, ph[13:0]};
					state_q <= S_POLY;
				end
				S_POLY: begin
					if (step_q == 3'd1) z2_q <= pq14;
					if (step_q == 3'd4) begin
						s_q[sin_idx_q] <= quad_q[1] ? -14'(sq) : 14'(sq);
						step_q <= '0;
						if (sin_idx_q == 2'd3) state_q <= S_WT;
						else begin
							sin_idx_q <= sin_idx_q + 2'd1;
							state_q <= S_ANG;
						end
					end else step_q <= step_q + 3'd1;
				end
				S_WT: begin
					if (step_q == 3'd1) sumx_q <= 17'(s_q[0]) + wt_term;
					if (step_q == 3'd2) begin
						nx_q <= sat16(sumx_q);
						ny_q <= sat16(17'(s_q[2]) + wt_term);
						step_q <= '0;
						state_q <= S_SCL;
					end else step_q <= step_q + 3'd1;
				end
				S_SCL: begin
					if (step_q == 3'd1) begin
						col_q <= col_v[7:0]; col_ok_q <= col_in;
					end
					if (step_q == 3'd2) begin
						wr_q <= plot_q && col_ok_q && row_in;
						if (plot_q && col_ok_q && row_in) row_q <= row_v[7:0];
						else begin
							col_q <= '0; row_q <= '0;
						end
						step_q <= '0;
						state_q <= S_OUT;
					end else step_q <= step_q + 3'd1;
				end
				S_OUT: if (out_free) begin
					// hold here while the previous result still waits
					point_x <= nx_q; point_y <= ny_q;
					pixel_col <= col_q; pixel_row <= row_q; pixel_write <= wr_q;
					cx_q <= nx_q; cy_q <= ny_q;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== hdl/cap_checker.sv =====
// Port-level checker for the Clifford attractor plotter, bound to the top.
// Depends on cap_pkg.
module cap_checker import cap_pkg::*; (
	input logic clk, arst_n, in_valid, in_ready, out_valid, out_ready,
	input logic signed [15:0] point_x, point_y,
	input logic [7:0] pixel_col, pixel_row,
	input logic pixel_write
);
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready) else $error("ready right after accept");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(point_x) && $stable(point_y)
		&& $stable(pixel_col) && $stable(pixel_row) && $stable(pixel_write)))
		else $error("result changed while waiting");
	a_zero_pix: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !pixel_write) |-> (pixel_col == 8'd0 && pixel_row == 8'd0))
		else $error("pixel not cleared");
endmodule
bind clifford_attractor_plotter_top cap_checker u_cap_checker (.*);
